// ===== hw/rtl/lhp_pkg.sv =====
// Shared types and constants of the latency histogram percentile unit.
package lhp_pkg;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REPORT = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   localparam int unsigned BaseNs   = 10000;
   localparam int unsigned FracBits = 20;
   localparam int unsigned EdgeDiv  = 50;
   localparam logic [9:0]  PermilleReset = 10'd950;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_CLR  = 9'b000000010,
      ST_SRD  = 9'b000000100,
      ST_SCMP = 9'b000001000,
      ST_BRD  = 9'b000010000,
      ST_BWR  = 9'b000100000,
      ST_WALK = 9'b001000000,
      ST_DIV  = 9'b010000000,
      ST_RESP = 9'b100000000
   } state_type;

endpackage

// ===== hw/rtl/lhp_if.sv =====
// Handshake channels of the latency histogram percentile unit.
interface lhp_req_if;
   import lhp_pkg::*;
   logic        valid;
   logic        ready;
   op_type      op;
   logic [31:0] sample_ns;
   modport source (output valid, output op, output sample_ns, input ready);
   modport sink (input valid, input op, input sample_ns, output ready);
endinterface

interface lhp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] sample_count;
   logic [31:0] mean_ns;
   logic [31:0] percentile_ns;
   logic [31:0] max_ns;
   modport source (output valid, output sample_count, output mean_ns,
                   output percentile_ns, output max_ns, input ready);
   modport sink (input valid, input sample_count, input mean_ns,
                 input percentile_ns, input max_ns, output ready);
endinterface

// ===== hw/rtl/lhp_div.sv =====
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
module lhp_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [32:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], quo_ff[63]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/latency_histogram_percentile.sv =====
// Latency statistics with a geometric histogram: an add transfer runs a binary
// search over the edge ROM, each step an edge read (ST_SRD) and a compare
// (ST_SCMP), then a read-modify-write of the selected bin; a report on a
// non-empty histogram walks the bin memory at one bin a cycle and then runs
// the mean divider; a clear, and reset, sweep the bin memory, during which
// no transfer is taken.
module latency_histogram_percentile
   import lhp_pkg::*;
#(
   parameter int BIN_COUNT = 600
) (
   input  logic       clock,
   input  logic       reset,
   lhp_req_if.sink    req_chan,
   lhp_rsp_if.source  rsp_chan,
   input  logic       csr_wr_en,
   input  logic [9:0] csr_wr_data
);
   localparam int IW = $clog2(BIN_COUNT);
   localparam logic [IW-1:0] LastIdx = IW'(BIN_COUNT - 1);

   typedef logic [31:0] edge_arr_type [BIN_COUNT];

   function automatic edge_arr_type build_edges();
      edge_arr_type t;
      logic [63:0]  e;
      logic [63:0]  r;
      logic         sat;
      e   = 64'(BaseNs) << FracBits;
      sat = 1'b0;
      for (int b = 0; b < BIN_COUNT; b++) begin
         if (!sat) begin
            r = (e + (64'd1 << (FracBits - 1))) >> FracBits;
            if (r >= 64'hFFFF_FFFF || e >= (64'hFFFF_FFFF << FracBits)) begin
               sat = 1'b1;
            end else begin
               t[b] = r[31:0];
               e    = e + e / EdgeDiv;
            end
         end
         if (sat) t[b] = 32'hFFFF_FFFF;
      end
      return t;
   endfunction

   localparam edge_arr_type EDGE_ROM = build_edges();

   state_type     state_ff, state_in;
   logic [9:0]    permille_ff;
   logic [31:0]   count_ff, count_in;
   logic [63:0]   sum_ff, sum_in;
   logic [31:0]   max_ff, max_in;
   logic [31:0]   x_ff, x_in;
   logic [IW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [IW-1:0] bin_sel_ff, bin_sel_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          pend_ff, pend_in, last_ff, last_in, issued_ff, issued_in;
   logic [63:0]   seen_ff, seen_in;
   logic [41:0]   prod_ff, prod_in;
   logic [31:0]   pct_ff, pct_in, mean_ff, mean_in;
   logic          div_start_ff, div_start_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_count_ff, rsp_count_in, rsp_mean_ff, rsp_mean_in;
   logic [31:0]   rsp_pct_ff, rsp_pct_in, rsp_max_ff, rsp_max_in;

   logic [31:0]   bin_mem [BIN_COUNT];
   logic [31:0]   bin_q_ff;
   logic [31:0]   edge_q_ff;
   logic          bin_we;
   logic [IW-1:0] bin_waddr, bin_raddr, edge_addr;
   logic [31:0]   bin_wdata;

   logic [IW:0]   mid_sum;
   logic [64:0]   sum_ext;
   logic [63:0]   acc;
   logic          div_done;
   logic [63:0]   div_quo;
   logic          accept;

   assign accept  = req_chan.valid && req_chan.ready;
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign sum_ext = {1'b0, sum_ff} + 65'(req_chan.sample_ns);
   assign acc     = seen_ff + (64'(bin_q_ff) << 10) - (64'(bin_q_ff) << 4)
                    - (64'(bin_q_ff) << 3);

   lhp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      max_in       = max_ff;
      x_in         = x_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      bin_sel_in   = bin_sel_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      last_in      = last_ff;
      issued_in    = issued_ff;
      seen_in      = seen_ff;
      prod_in      = prod_ff;
      pct_in       = pct_ff;
      mean_in      = mean_ff;
      div_start_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_count_in = rsp_count_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_pct_in   = rsp_pct_ff;
      rsp_max_in   = rsp_max_ff;
      bin_we       = 1'b0;
      bin_waddr    = idx_ff;
      bin_wdata    = '0;
      bin_raddr    = idx_ff;
      edge_addr    = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.op)
                  OP_ADD: begin
                     if (count_ff != 32'hFFFF_FFFF) count_in = count_ff + 32'd1;
                     sum_in = sum_ext[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_ext[63:0];
                     if (req_chan.sample_ns > max_ff) max_in = req_chan.sample_ns;
                     x_in     = req_chan.sample_ns;
                     lo_in    = '0;
                     hi_in    = LastIdx;
                     state_in = ST_SRD;
                  end
                  OP_REPORT: begin
                     if (count_ff == '0) begin
                        pct_in   = '0;
                        mean_in  = '0;
                        state_in = ST_RESP;
                     end else begin
                        prod_in   = 42'(count_ff) * 42'(permille_ff);
                        idx_in    = '0;
                        issued_in = 1'b0;
                        seen_in   = '0;
                        state_in  = ST_WALK;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     sum_in   = '0;
                     max_in   = '0;
                     idx_in   = '0;
                     state_in = ST_CLR;
                  end
                  default: ;
               endcase
            end
         end
         ST_CLR: begin
            bin_we    = 1'b1;
            bin_waddr = idx_ff;
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == LastIdx) state_in = ST_IDLE;
         end
         ST_SRD: begin
            if (lo_ff == hi_ff) begin
               // a sample equal to the first edge still falls in bin 0
               bin_sel_in = (x_ff == EDGE_ROM[0]) ? '0 : lo_ff;
               state_in   = ST_BRD;
            end else begin
               mid_in    = mid_sum[IW:1];
               edge_addr = mid_sum[IW:1];
               state_in  = ST_SCMP;
            end
         end
         ST_SCMP: begin
            if (edge_q_ff <= x_ff) lo_in = mid_ff + 1'b1;
            else                   hi_in = mid_ff;
            state_in = ST_SRD;
         end
         ST_BRD: begin
            bin_raddr = bin_sel_ff;
            state_in  = ST_BWR;
         end
         ST_BWR: begin
            bin_we    = 1'b1;
            bin_waddr = bin_sel_ff;
            bin_wdata = (bin_q_ff == 32'hFFFF_FFFF) ? bin_q_ff : bin_q_ff + 32'd1;
            state_in  = ST_IDLE;
         end
         ST_WALK: begin
            // running total is kept times 1000 against count*permille
            if (!issued_ff) begin
               idx_in  = idx_ff + 1'b1;
               pend_in = 1'b1;
               last_in = (idx_ff == LastIdx);
               if (idx_ff == LastIdx) issued_in = 1'b1;
            end
            if (pend_ff) begin
               seen_in = acc;
               if (acc >= 64'(prod_ff)) begin
                  pct_in       = (edge_q_ff < max_ff) ? edge_q_ff : max_ff;
                  div_start_in = 1'b1;
                  state_in     = ST_DIV;
               end else if (last_ff) begin
                  pct_in       = max_ff;
                  div_start_in = 1'b1;
                  state_in     = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               mean_in  = (div_quo[63:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               rsp_mean_in  = mean_ff;
               rsp_pct_in   = pct_ff;
               rsp_max_in   = max_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (bin_we) bin_mem[bin_waddr] <= bin_wdata;
      bin_q_ff  <= bin_mem[bin_raddr];
      edge_q_ff <= EDGE_ROM[edge_addr];
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      bin_sel_ff   <= bin_sel_in;
      last_ff      <= last_in;
      issued_ff    <= issued_in;
      seen_ff      <= seen_in;
      prod_ff      <= prod_in;
      pct_ff       <= pct_in;
      mean_ff      <= mean_in;
      rsp_count_ff <= rsp_count_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_pct_ff   <= rsp_pct_in;
      rsp_max_ff   <= rsp_max_in;
      if (reset) begin
         state_ff     <= ST_CLR;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         sum_ff       <= '0;
         max_ff       <= '0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         permille_ff  <= PermilleReset;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         max_ff       <= max_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) permille_ff <= csr_wr_data;
      end
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.sample_count  = rsp_count_ff;
   assign rsp_chan.mean_ns       = rsp_mean_ff;
   assign rsp_chan.percentile_ns = rsp_pct_ff;
   assign rsp_chan.max_ns        = rsp_max_ff;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> state_ff == ST_CLR)
      else $error("clearing pass not started after reset");

   a_empty_stats: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> (sum_ff == '0 && max_ff == '0))
      else $error("sum or maximum non-zero with no samples");

   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCMP |-> (lo_ff <= mid_ff && mid_ff < hi_ff))
      else $error("binary search midpoint out of range");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("result raised outside the response state");

endmodule
